/* src/bmtb_pkg.sv */
`default_nettype none

package bmtb_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_WINDOW_DEF = 7;
  localparam int MAX_HEIGHT     = 1024;

  localparam int PIX_W      = 8;
  localparam int FRAME_W    = 11;
  localparam int WIN_W      = 3;
  localparam int THR_W      = 8;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int ROW_W      = 10;
  localparam int KK_W       = 6;   // k*k, k <= 7
  localparam int LIM_W      = 15;  // (thr+1)*k*k <= 12544

  localparam logic [PIX_W-1:0] LEVEL_FG = 8'd255;
  localparam logic [PIX_W-1:0] LEVEL_BG = 8'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH     = 2'd0,
    CFG_FRAME_HEIGHT    = 2'd1,
    CFG_WINDOW_SIZE     = 2'd2,
    CFG_LEVEL_THRESHOLD = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_width;
    logic [FRAME_W-1:0] frame_height;
    logic [WIN_W-1:0]   window_size;
  } geom_cfg_t;

  // per-item control that rides along the pipe
  typedef struct packed {
    logic emit;
    logic fend;
  } item_ctl_t;

endpackage

`default_nettype wire

/* src/box_mean_threshold_binarizer_core.sv */
// Channel   Signals                                        Width
// ------    ---------------------------------------------  ----------------
// in        in_valid/in_ready, in_pixel, in_frame_start    8, 1
// out       out_valid/out_ready, out_level, out_frame_end  8, 1
// cfg       cfg_wr_en, cfg_index, cfg_data                 2 index, 11 data
//
// One pixel per clock when out_ready stays high. A result passes position
// and line read, column sum, window sum and compare before it reaches the
// output register. Synchronous active-low reset clears counters, valid bits
// and config; the line store has no reset and no clearing pass.
// Each stage holds while the one after it is full and stalled; bubbles
// collapse, so input keeps flowing while a result waits on out_ready.
`default_nettype none

module box_mean_threshold_binarizer_core import bmtb_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [PIX_W-1:0]      in_pixel,
  input  wire logic                  in_frame_start,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [PIX_W-1:0]           out_level,
  output logic                       out_frame_end,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int LINES  = (MAX_WINDOW > 1) ? MAX_WINDOW - 1 : 1;
  localparam int WSUM_W = $clog2(MAX_WINDOW * MAX_WINDOW * 255 + 1);
  localparam int CMP_W  = (WSUM_W > LIM_W) ? WSUM_W : LIM_W;

  // config registers
  logic [FRAME_W-1:0] frame_width_r, frame_height_r;
  logic [WIN_W-1:0]   window_size_r;
  logic [THR_W-1:0]   level_threshold_r;
  geom_cfg_t          geom;

  // decision limit: sum >= (thr+1)*k*k means mean > thr
  logic [WIN_W-1:0]   win_k;
  logic [KK_W-1:0]    kk_r;
  logic [LIM_W-1:0]   limit_r;

  // pipeline control
  logic      en1, en2, en3, en4, en_out, accept;
  logic      v1_r, v2_r, v3_r, v4_r;
  item_ctl_t ctl0, ctl1_r, ctl2_r, ctl3_r, ctl4_r;

  // stage 1 payload
  logic [CW-1:0]                  col0, c1_r;
  logic [PIX_W-1:0]               pix1_r;
  logic [LINES-1:0][PIX_W-1:0]    lines;
  logic [MAX_WINDOW-1:0][PIX_W-1:0] col1;

  logic [WSUM_W-1:0]  wsum;

  // output register
  logic               out_valid_r, frame_end_r;
  logic [PIX_W-1:0]   level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r     <= FRAME_W'(512);
      frame_height_r    <= FRAME_W'(512);
      window_size_r     <= WIN_W'(3);
      level_threshold_r <= THR_W'(128);
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FRAME_WIDTH:     frame_width_r     <= cfg_data;
        CFG_FRAME_HEIGHT:    frame_height_r    <= cfg_data;
        CFG_WINDOW_SIZE:     window_size_r     <= cfg_data[WIN_W-1:0];
        CFG_LEVEL_THRESHOLD: level_threshold_r <= cfg_data[THR_W-1:0];
      endcase
    end
  end

  assign geom = '{frame_width:  frame_width_r,
                  frame_height: frame_height_r,
                  window_size:  window_size_r};

  // 2-step product, lag hidden: user moves config only while idle; unchecked
  always_ff @(posedge clk) begin
    kk_r    <= KK_W'(win_k) * KK_W'(win_k);
    limit_r <= (LIM_W'(level_threshold_r) + LIM_W'(1)) * LIM_W'(kk_r);
  end

  // stage enables: a stage loads when empty or when it drains
  always_comb begin
    en_out   = !out_valid_r || out_ready;
    en4      = !v4_r || en_out;
    en3      = !v3_r || en4;
    en2      = !v2_r || en3;
    en1      = !v1_r || en2;
    in_ready = en1;
    accept   = in_valid && en1;
  end

  // stage 0: raster position, window-complete and frame-end flags
  bmtb_pos #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_pos (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (geom),
    .accept      (accept),
    .frame_start (in_frame_start),
    .col         (col0),
    .win_k       (win_k),
    .ctl         (ctl0)
  );

  // line store read whenever stage 1 loads, written as the item leaves stage 1
  bmtb_linebuf #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_linebuf (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (en1),
    .rd_addr (col0),
    .wr_en   (v1_r && en2),
    .wr_addr (c1_r),
    .wr_pix  (pix1_r),
    .lines   (lines)
  );

  // newest window column: current pixel on top, older rows below
  always_comb begin
    col1[0] = pix1_r;
    for (int y = 1; y < MAX_WINDOW; y++) begin
      col1[y] = lines[y-1];
    end
  end

  bmtb_window #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_window (
    .clk    (clk),
    .win_k  (win_k),
    .col_in (col1),
    .ld2    (en2),
    .shift3 (v2_r && en3),
    .ld4    (en4),
    .wsum   (wsum)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      ctl1_r <= ctl0;
      pix1_r <= in_pixel;
      c1_r   <= col0;
    end
    if (en2) ctl2_r <= ctl1_r;
    if (en3) ctl3_r <= ctl2_r;
    if (en4) ctl4_r <= ctl3_r;
  end

  // stage 4: compare and load the output register; items with no
  // complete window drop out here
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en_out) begin
      out_valid_r <= v4_r && ctl4_r.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      level_r     <= (CMP_W'(wsum) >= CMP_W'(limit_r)) ? LEVEL_FG : LEVEL_BG;
      frame_end_r <= ctl4_r.fend;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_level     = level_r;
  assign out_frame_end = frame_end_r;

endmodule

`default_nettype wire

/* src/bmtb_pos.sv */
`default_nettype none

module bmtb_pos import bmtb_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_WINDOW = MAX_WINDOW_DEF,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire geom_cfg_t       cfg,
  input  wire logic            accept,
  input  wire logic            frame_start,
  output logic [CW-1:0]        col,
  output logic [WIN_W-1:0]     win_k,
  output item_ctl_t            ctl
);

  localparam int XW = (CW + 1 > FRAME_W) ? CW + 1 : FRAME_W;

  logic [CW-1:0]      col_r, col_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [XW-1:0]      fw_x, w, c_x;
  logic [FRAME_W-1:0] h, r_inc, r1;
  logic [CW-1:0]      c_a;
  logic [ROW_W-1:0]   r_a, r_b;

  always_comb begin
    fw_x = XW'(cfg.frame_width);
    if (fw_x == '0) begin
      w = XW'(1);
    end else if (fw_x > XW'(MAX_WIDTH)) begin
      w = XW'(MAX_WIDTH);
    end else begin
      w = fw_x;
    end

    if (cfg.frame_height == '0) begin
      h = FRAME_W'(1);
    end else if (cfg.frame_height > FRAME_W'(MAX_HEIGHT)) begin
      h = FRAME_W'(MAX_HEIGHT);
    end else begin
      h = cfg.frame_height;
    end

    if (cfg.window_size == '0) begin
      win_k = WIN_W'(1);
    end else if (int'(cfg.window_size) > MAX_WINDOW) begin
      win_k = WIN_W'(MAX_WINDOW);
    end else begin
      win_k = cfg.window_size;
    end

    // position of this pixel; frame start restarts at the origin
    c_a = frame_start ? '0 : col_r;
    r_a = frame_start ? '0 : row_r;
    // width shrunk under the current column: close the row first
    if (XW'(c_a) >= w) begin
      c_a   = '0;
      r_inc = FRAME_W'(r_a) + FRAME_W'(1);
    end else begin
      r_inc = FRAME_W'(r_a);
    end
    r_b = (r_inc >= h) ? '0 : r_inc[ROW_W-1:0];

    c_x = XW'(c_a) + XW'(1);
    r1  = FRAME_W'(r_b) + FRAME_W'(1);

    ctl.emit = (r1 >= FRAME_W'(win_k)) && (c_x >= XW'(win_k));
    ctl.fend = (r1 == h) && (c_x == w);
    col      = c_a;

    if (c_x >= w) begin
      col_nxt = '0;
      row_nxt = (r1 >= h) ? '0 : r1[ROW_W-1:0];
    end else begin
      col_nxt = c_x[CW-1:0];
      row_nxt = r_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

`default_nettype wire

/* src/bmtb_linebuf.sv */
`default_nettype none

module bmtb_linebuf import bmtb_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_WINDOW = MAX_WINDOW_DEF,
  localparam int CW    = $clog2(MAX_WIDTH),
  localparam int LINES = (MAX_WINDOW > 1) ? MAX_WINDOW - 1 : 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          rd_en,
  input  wire logic [CW-1:0]                 rd_addr,
  input  wire logic                          wr_en,
  input  wire logic [CW-1:0]                 wr_addr,
  input  wire logic [PIX_W-1:0]              wr_pix,
  output logic [LINES-1:0][PIX_W-1:0]        lines
);

  // one word per column: all stored rows of that column
  logic [LINES-1:0][PIX_W-1:0] mem [MAX_WIDTH];
  logic [LINES-1:0][PIX_W-1:0] rdata_r, fwd_r, wr_word;
  logic                        hit_r;

  always_comb begin
    lines      = hit_r ? fwd_r : rdata_r;
    // rows age by one: newest pixel at line 0
    wr_word[0] = wr_pix;
    for (int i = 1; i < LINES; i++) begin
      wr_word[i] = lines[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
      fwd_r   <= wr_word;
    end
  end

  // same column written in the cycle it is read: take the write data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (rd_en) begin
      hit_r <= wr_en && (wr_addr == rd_addr);
    end
  end

endmodule

`default_nettype wire

/* src/bmtb_window.sv */
`default_nettype none

module bmtb_window import bmtb_pkg::*; #(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF,
  localparam int CSUM_W = $clog2(MAX_WINDOW * 255 + 1),
  localparam int WSUM_W = $clog2(MAX_WINDOW * MAX_WINDOW * 255 + 1)
) (
  input  wire logic                             clk,
  input  wire logic [WIN_W-1:0]                 win_k,
  input  wire logic [MAX_WINDOW-1:0][PIX_W-1:0] col_in,
  input  wire logic                             ld2,
  input  wire logic                             shift3,
  input  wire logic                             ld4,
  output logic [WSUM_W-1:0]                     wsum
);

  logic [MAX_WINDOW-1:0][PIX_W-1:0]                  col2_r;
  logic [MAX_WINDOW-1:0][CSUM_W-1:0]                 psum;
  logic [MAX_WINDOW-1:0][MAX_WINDOW-1:0][CSUM_W-1:0] psum_r;
  logic [WSUM_W-1:0]                                 wsum_c, wsum_r;
  logic [WIN_W-1:0]                                  krow;

  // running sums down the newest column: entry y covers rows 0..y, so the
  // row count is picked at the window sum with the current k
  always_comb begin
    psum[0] = CSUM_W'(col2_r[0]);
    for (int y = 1; y < MAX_WINDOW; y++) begin
      psum[y] = psum[y-1] + CSUM_W'(col2_r[y]);
    end
  end

  assign krow = win_k - WIN_W'(1);

  // horizontal sum over the k newest columns, k rows each
  always_comb begin
    wsum_c = '0;
    for (int x = 0; x < MAX_WINDOW; x++) begin
      if (x < int'(win_k)) begin
        wsum_c = wsum_c + WSUM_W'(psum_r[x][krow]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld2) begin
      col2_r <= col_in;
    end
    if (shift3) begin
      psum_r[0] <= psum;
      for (int x = 1; x < MAX_WINDOW; x++) begin
        psum_r[x] <= psum_r[x-1];
      end
    end
    if (ld4) begin
      wsum_r <= wsum_c;
    end
  end

  assign wsum = wsum_r;

endmodule

`default_nettype wire

/* src/bmtb_checker.sv */
`default_nettype none

module bmtb_checker import bmtb_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire logic [PIX_W-1:0]      in_pixel,
  input wire logic                  in_frame_start,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [PIX_W-1:0]      out_level,
  input wire logic                  out_frame_end
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_level) &&
                                $stable(out_frame_end))
    else $error("result changed while stalled");

  // a waiting pixel keeps its payload
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_pixel) &&
                              $stable(in_frame_start))
    else $error("input changed while stalled");

  a_level_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_level == LEVEL_FG || out_level == LEVEL_BG))
    else $error("level not binary");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result out right after reset");

  // with the output register empty nothing can back up to the input
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind box_mean_threshold_binarizer_core bmtb_checker u_bmtb_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_pixel       (in_pixel),
  .in_frame_start (in_frame_start),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_level      (out_level),
  .out_frame_end  (out_frame_end)
);

`default_nettype wire

/* verif/bmtb_checker.sv */
module box_mean_level_checker import bmtb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [PIX_W-1:0]      in_pixel,
  input  logic                  in_frame_start,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [PIX_W-1:0]      out_level,
  input  logic                  out_frame_end,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatch_count,
  output int                    pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINES = MAX_WINDOW_DEF - 1;

  typedef struct packed {
    logic [PIX_W-1:0] level;
    logic             frame_end;
  } bin_pixel_t;

  // line buffers: [age of row][column]; window: [age of column][row]
  logic [PIX_W-1:0]   line_mem [LINES][MAX_WIDTH_DEF];
  logic [PIX_W-1:0]   win_mem [MAX_WINDOW_DEF][MAX_WINDOW_DEF];
  int unsigned        col_pos;
  int unsigned        row_pos;
  logic [FRAME_W-1:0] width_q;
  logic [FRAME_W-1:0] height_q;
  logic [WIN_W-1:0]   win_q;
  logic [THR_W-1:0]   thr_q;
  bin_pixel_t         expected_pixels [$];
  int                 fails = 0;

  assign mismatch_count = fails;

  function automatic int unsigned clamp_range(int unsigned v, int unsigned hi);
    return (v == 0) ? 1 : ((v > hi) ? hi : v);
  endfunction

  task automatic shift_in_pixel(logic [PIX_W-1:0] pix, logic fs);
    int unsigned w;
    int unsigned h;
    int unsigned k;
    int unsigned thr;
    int unsigned sum;
    bin_pixel_t  res;
    w   = clamp_range(width_q, MAX_WIDTH_DEF);
    h   = clamp_range(height_q, MAX_HEIGHT);
    k   = clamp_range(win_q, MAX_WINDOW_DEF);
    thr = thr_q;
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    // a shrunk width or height may leave the position outside the frame
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;

    for (int a = MAX_WINDOW_DEF - 1; a >= 1; a--)
      for (int r = 0; r < MAX_WINDOW_DEF; r++)
        win_mem[a][r] = win_mem[a-1][r];
    win_mem[0][0] = pix;
    for (int r = 1; r < MAX_WINDOW_DEF; r++)
      win_mem[0][r] = line_mem[r-1][col_pos];
    for (int r = LINES - 1; r >= 1; r--)
      line_mem[r][col_pos] = line_mem[r-1][col_pos];
    line_mem[0][col_pos] = pix;

    if (row_pos + 1 >= k && col_pos + 1 >= k) begin
      sum = 0;
      for (int a = 0; a < k; a++)
        for (int r = 0; r < k; r++)
          sum += win_mem[a][r];
      res.level     = (sum >= (thr + 1) * k * k) ? LEVEL_FG : LEVEL_BG;
      res.frame_end = (row_pos + 1 == h) && (col_pos + 1 == w);
      expected_pixels.push_back(res);
    end

    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  always @(posedge clk) begin : watch
    bin_pixel_t exp_px;
    if (!rst_n) begin
      foreach (line_mem[i, j]) line_mem[i][j] = '0;
      foreach (win_mem[i, j]) win_mem[i][j] = '0;
      col_pos  = 0;
      row_pos  = 0;
      width_q  = 11'd512;
      height_q = 11'd512;
      win_q    = 3'd3;
      thr_q    = 8'd128;
      expected_pixels.delete();
      pending_results <= 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_idx_t'(cfg_index))
          CFG_FRAME_WIDTH:     width_q  = cfg_data[FRAME_W-1:0];
          CFG_FRAME_HEIGHT:    height_q = cfg_data[FRAME_W-1:0];
          CFG_WINDOW_SIZE:     win_q    = cfg_data[WIN_W-1:0];
          CFG_LEVEL_THRESHOLD: thr_q    = cfg_data[THR_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) shift_in_pixel(in_pixel, in_frame_start);
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: result with none expected, level %0d frame_end %0d",
                   $time, out_level, out_frame_end);
          fails++;
        end else begin
          exp_px = expected_pixels.pop_front();
          if (out_level !== exp_px.level) begin
            $display("%0t: level mismatch, expected %0d, got %0d",
                     $time, exp_px.level, out_level);
            fails++;
          end
          if (out_frame_end !== exp_px.frame_end) begin
            $display("%0t: frame_end mismatch, expected %0d, got %0d",
                     $time, exp_px.frame_end, out_frame_end);
            fails++;
          end
        end
      end
      pending_results <= expected_pixels.size();
    end
  end

endmodule

/* verif/box_mean_threshold_binarizer_core_test.sv */
module box_mean_threshold_binarizer_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import bmtb_pkg::*;

  // Pixels that give no result still need to flush through the pipe before
  // the config may change.
  localparam int SETTLE_CYCLES = 12;
  // Cycles with no transfer at all before we call it a hang.
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_ITEMS  = 400;

  typedef enum {PIX_RANDOM, PIX_EXTREME, PIX_NEAR, PIX_FIXED} pixel_mix_t;

  logic                  clk            = 1'b0;
  logic                  rst_n          = 1'b0;
  logic                  in_valid       = 1'b0;
  logic [PIX_W-1:0]      in_pixel       = '0;
  logic                  in_frame_start = 1'b0;
  logic                  out_ready      = 1'b0;
  logic                  cfg_wr_en      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index      = CFG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data       = '0;
  logic                  in_ready;
  logic                  out_valid;
  logic [PIX_W-1:0]      out_level;
  logic                  out_frame_end;
  int                    mismatch_count;
  int                    pending_results;
  int                    idle_cycles = 0;
  bit                    in_steady   = 1'b0;  // sender: no gaps this phase
  bit                    out_steady  = 1'b0;  // receiver: no stalls for a while

  initial begin
    forever #4 clk = ~clk;
  end

  box_mean_threshold_binarizer_core i_dut (.*);

  box_mean_level_checker i_checker (.*);

  // Hang detector: any transfer on either channel restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: random stall before each result, with stretches where
  // out_ready just stays up.
  initial begin : sink
    int stall;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = out_steady ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if ($urandom_range(0, 31) == 0) out_steady = !out_steady;
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // Drop valid, wait for every expected result, then let the pipe empty.
  task automatic settle_block();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Config only changes with the block idle; all four regs each time.
  task automatic start_phase(int w, int h, int k, int thr);
    settle_block();
    write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(w));
    write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(h));
    write_reg(CFG_WINDOW_SIZE, CFG_DATA_W'(k));
    write_reg(CFG_LEVEL_THRESHOLD, CFG_DATA_W'(thr));
    cfg_wr_en <= 1'b0;
    in_steady = ($urandom_range(0, 3) == 0);
  endtask

  // One pixel transfer; valid holds with a stable payload until in_ready.
  task automatic send_pixel(logic [PIX_W-1:0] pix, logic fs);
    int gap;
    gap = in_steady ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_pixel       <= pix;
    in_frame_start <= fs;
    do @(posedge clk); while (!in_ready);
  endtask

  // cont = 1 keeps the current frame position (no frame_start on the first
  // pixel). Only used when the width did not grow, so every line-buffer
  // entry that a result uses was written earlier in the same frame.
  task automatic feed_pixels(int count, pixel_mix_t mix, logic [PIX_W-1:0] base, bit cont);
    logic [PIX_W-1:0] pix;
    logic             fs;
    for (int i = 0; i < count; i++) begin
      case (mix)
        PIX_RANDOM:  pix = PIX_W'($urandom_range(0, 255));
        PIX_EXTREME: pix = $urandom_range(0, 1) ? LEVEL_FG : LEVEL_BG;
        // thr and thr+1 only: window means land right on the compare edge
        PIX_NEAR:    pix = (base == 8'd255) ? base : base + PIX_W'($urandom_range(0, 1));
        default:     pix = base;
      endcase
      // rare frame_start mid-frame as noise
      fs = (i == 0) ? !cont : ($urandom_range(0, 99) == 0);
      // occasional hold-off until the output side has fully caught up
      if ($urandom_range(0, 149) == 0) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results != 0);
      end
      send_pixel(pix, fs);
    end
  endtask

  initial begin : stim
    int         w;
    int         h;
    int         k;
    int         thr;
    int         n;
    int         eff_w;
    int         eff_h;
    int         prev_eff_w;
    int         fed;
    bit         cont;
    pixel_mix_t mix;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // all-255 window with threshold 254: sum sits exactly on the limit
    start_phase(2, 2, 2, 254);
    feed_pixels(4, PIX_FIXED, 8'd255, 1'b0);
    // zero width, height and window act as 1; every pixel is a whole frame
    start_phase(0, 0, 0, 0);
    feed_pixels(1, PIX_FIXED, 8'd0, 1'b0);
    feed_pixels(1, PIX_FIXED, 8'd1, 1'b1);
    feed_pixels(1, PIX_FIXED, 8'd0, 1'b1);
    // window wider than the frame: nothing may come out
    start_phase(2, 3, 3, 0);
    feed_pixels(6, PIX_RANDOM, 8'd0, 1'b0);
    // stop at row 2 col 2, then shrink to 2x2: row ends, then row wraps
    start_phase(3, 3, 2, 100);
    feed_pixels(8, PIX_NEAR, 8'd100, 1'b0);
    start_phase(2, 2, 2, 100);
    feed_pixels(4, PIX_NEAR, 8'd100, 1'b1);

    // random phases: small frames, mostly whole frames of random content
    prev_eff_w = 2;
    fed        = 0;
    while (fed < RANDOM_ITEMS) begin
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 12);
      h = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 8);
      k = $urandom_range(0, 7);
      case ($urandom_range(0, 3))
        0:       thr = 0;
        1:       thr = 255;
        default: thr = $urandom_range(0, 255);
      endcase
      eff_w = (w == 0) ? 1 : w;
      eff_h = (h == 0) ? 1 : h;
      cont  = (eff_w <= prev_eff_w) && ($urandom_range(0, 2) == 0);
      n     = eff_w * eff_h * $urandom_range(1, 3) + $urandom_range(0, eff_w);
      if (n > 120) n = 120;
      mix   = pixel_mix_t'($urandom_range(0, 2));
      start_phase(w, h, k, thr);
      feed_pixels(n, mix, PIX_W'(thr), cont);
      fed        += n;
      prev_eff_w  = eff_w;
    end

    settle_block();
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
